// ===== sv/dlprc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlprc_pkg: shared types and constants of the door latch controller
// Register indexes, status codes, config bundle and result beat layout.
// ----------------------------------------------------------------------------
package dlprc_pkg;

  // timer width default
  localparam int TIMER_WIDTH_DEF = 16;

  // config port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_WAIT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT  = 3'd4;

  // register reset values
  localparam logic [15:0] PULSE_TICKS_RST     = 16'd200;
  localparam logic [15:0] FAIL_WAIT_TICKS_RST = 16'd400;
  localparam logic [3:0]  MAX_ATTEMPTS_RST    = 4'd3;
  localparam logic [15:0] SAMPLE_TICKS_RST    = 16'd20;
  localparam logic [2:0]  DEBOUNCE_LIMIT_RST  = 3'd5;

  // item kinds
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // door status codes
  localparam logic [1:0] DOOR_CLOSED = 2'd0;
  localparam logic [1:0] DOOR_OPEN   = 2'd1;
  localparam logic [1:0] DOOR_FAULT  = 2'd2;

  // sequence phase
  localparam logic PH_IDLE   = 1'b0;
  localparam logic PH_ACTIVE = 1'b1;

  // beat widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic [15:0] pulse_ticks;
    logic [15:0] fail_wait_ticks;
    logic [3:0]  max_attempts;
    logic [15:0] sample_ticks;
    logic [2:0]  debounce_limit;
  } cfg_t;

  typedef struct packed {
    logic       opening_active;
    logic       request_busy;
    logic [1:0] door_status;
    logic       latch_drive;
  } result_t;

endpackage

// ===== sv/door_latch_pulse_retry_controller_top.sv =====
// ----------------------------------------------------------------------------
// door_latch_pulse_retry_controller_top: door latch pulse and retry controller
// Drives a latch pulse per open request, retries on failure, declares a fault
// and debounces the sensor back out of fault.
//
//   channel  | direction | beat content
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | tuser: action; tdata: sensor_open
//   m_axis   | out       | tdata: latch_drive, door_status, request_busy,
//            |           |        opening_active
//   cfg      | in        | cfg_index, cfg_data
//
// One result beat per input beat; a beat can be taken every cycle while
// the output buffer has room. Each beat passes the input register, then
// the state update into the output buffer. The two-entry output buffer
// keeps input accepted through one beat of output stall. Synchronous reset
// clears all state and loads register defaults.
// ----------------------------------------------------------------------------
module door_latch_pulse_retry_controller_top #(
  parameter int TIMER_WIDTH = dlprc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input beat
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [dlprc_pkg::IN_DATA_W-1:0]      s_tdata,  // [0] sensor_open
  input  logic                                 s_tuser,  // [0] action
  // result beat
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] latch_drive, [2:1] door_status, [3] request_busy, [4] opening_active
  output logic [dlprc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dlprc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dlprc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dlprc_pkg::cfg_t    cfg;
  dlprc_pkg::result_t res;
  logic               res_valid;
  logic               res_room;

  // register file
  dlprc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // controller
  dlprc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .action      (s_tuser),
    .sensor_open (s_tdata[0]),
    .res_valid   (res_valid),
    .res         (res),
    .res_room    (res_room)
  );

  // output buffer
  dlprc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/dlprc_cfg.sv =====
// ----------------------------------------------------------------------------
// dlprc_cfg: configuration register file
// Holds the five timing and limit registers, written one beat at a time.
// ----------------------------------------------------------------------------
module dlprc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dlprc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dlprc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dlprc_pkg::cfg_t                     cfg
);

  // writes are always accepted
  assign cfg_ready = 1'b1;

  // register writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks     <= dlprc_pkg::PULSE_TICKS_RST;
      cfg.fail_wait_ticks <= dlprc_pkg::FAIL_WAIT_TICKS_RST;
      cfg.max_attempts    <= dlprc_pkg::MAX_ATTEMPTS_RST;
      cfg.sample_ticks    <= dlprc_pkg::SAMPLE_TICKS_RST;
      cfg.debounce_limit  <= dlprc_pkg::DEBOUNCE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlprc_pkg::CFG_PULSE_TICKS:     cfg.pulse_ticks     <= cfg_data;
        dlprc_pkg::CFG_FAIL_WAIT_TICKS: cfg.fail_wait_ticks <= cfg_data;
        dlprc_pkg::CFG_MAX_ATTEMPTS:    cfg.max_attempts    <= cfg_data[3:0];
        dlprc_pkg::CFG_SAMPLE_TICKS:    cfg.sample_ticks    <= cfg_data;
        dlprc_pkg::CFG_DEBOUNCE_LIMIT:  cfg.debounce_limit  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/dlprc_core.sv =====
// ----------------------------------------------------------------------------
// dlprc_core: input register and controller state update
// Registers each accepted beat, then applies the request, pulse/retry and
// fault debounce rules in one pass and hands the result downstream.
// ----------------------------------------------------------------------------
module dlprc_core #(
  parameter int TIMER_WIDTH = dlprc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dlprc_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic                 sensor_open,
  output logic                 res_valid,
  output dlprc_pkg::result_t   res,
  input  logic                 res_room
);

  // compare width covers both timer and 16-bit thresholds
  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // input register
  logic st_valid;
  logic st_action;
  logic st_sensor;
  logic advance;

  // controller state
  logic                   opening_pending, opening_pending_next;
  logic                   phase, phase_next;
  logic [TIMER_WIDTH-1:0] elapsed_count, elapsed_count_next;
  logic [3:0]             attempt_count, attempt_count_next;
  logic [TIMER_WIDTH-1:0] sample_count, sample_count_next;
  logic signed [3:0]      debounce_level, debounce_level_next;
  logic [1:0]             door_state, door_state_next;
  logic                   drive_on, drive_on_next;
  logic                   busy;

  // helpers
  logic [CMP_W-1:0]       elapsed_w;
  logic [CMP_W-1:0]       sample_w;
  logic [3:0]             attempt_inc;
  logic signed [4:0]      lvl_up;
  logic signed [4:0]      lvl_dn;
  logic signed [4:0]      lim_pos;
  logic signed [4:0]      lim_neg;

  assign advance  = st_valid && res_room;
  assign in_ready = !st_valid || res_room;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_action <= action;
      st_sensor <= sensor_open;
    end
  end

  // next-state logic for one beat
  always_comb begin
    opening_pending_next = opening_pending;
    phase_next           = phase;
    elapsed_count_next   = elapsed_count;
    attempt_count_next   = attempt_count;
    sample_count_next    = sample_count;
    debounce_level_next  = debounce_level;
    door_state_next      = door_state;
    drive_on_next        = drive_on;
    busy                 = 1'b0;
    elapsed_w            = '0;
    sample_w             = '0;
    attempt_inc          = attempt_count + 4'd1;
    lvl_up               = 5'(debounce_level) + 5'sd1;
    lvl_dn               = 5'(debounce_level) - 5'sd1;
    lim_pos              = signed'({2'b00, cfg.debounce_limit});
    lim_neg              = -lim_pos;

    if (st_action == dlprc_pkg::ACT_REQUEST) begin
      busy                 = opening_pending;
      opening_pending_next = 1'b1;
    end else begin
      // opening sequence
      if (opening_pending) begin
        if (phase == dlprc_pkg::PH_IDLE) begin
          drive_on_next      = 1'b1;
          elapsed_count_next = '0;
          phase_next         = dlprc_pkg::PH_ACTIVE;
        end else begin
          if (elapsed_count != {TIMER_WIDTH{1'b1}}) begin
            elapsed_count_next = elapsed_count + 1'b1;
          end
          elapsed_w = CMP_W'(elapsed_count_next);
          if (elapsed_w >= CMP_W'(cfg.pulse_ticks)) begin
            drive_on_next = 1'b0;
            if (st_sensor) begin
              door_state_next      = dlprc_pkg::DOOR_OPEN;
              opening_pending_next = 1'b0;
              attempt_count_next   = '0;
              phase_next           = dlprc_pkg::PH_IDLE;
            end else if (elapsed_w >= CMP_W'(cfg.fail_wait_ticks)) begin
              attempt_count_next = attempt_inc;
              if (attempt_inc >= cfg.max_attempts) begin
                attempt_count_next   = '0;
                door_state_next      = dlprc_pkg::DOOR_FAULT;
                opening_pending_next = 1'b0;
              end
              phase_next = dlprc_pkg::PH_IDLE;
            end
          end
        end
      end

      // sample timer and fault debounce
      if (sample_count != {TIMER_WIDTH{1'b1}}) begin
        sample_count_next = sample_count + 1'b1;
      end
      sample_w = CMP_W'(sample_count_next);
      if (sample_w >= CMP_W'(cfg.sample_ticks)) begin
        sample_count_next = '0;
        if (door_state_next == dlprc_pkg::DOOR_FAULT) begin
          if (st_sensor) begin
            debounce_level_next = lvl_up[3:0];
            if (lvl_up >= lim_pos) begin
              debounce_level_next = lim_pos[3:0];
              door_state_next     = dlprc_pkg::DOOR_OPEN;
            end
          end else begin
            debounce_level_next = lvl_dn[3:0];
            if (lvl_dn <= lim_neg) begin
              debounce_level_next = lim_neg[3:0];
              door_state_next     = dlprc_pkg::DOOR_CLOSED;
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      opening_pending <= 1'b0;
      phase           <= dlprc_pkg::PH_IDLE;
      elapsed_count   <= '0;
      attempt_count   <= '0;
      sample_count    <= '0;
      debounce_level  <= '0;
      door_state      <= dlprc_pkg::DOOR_CLOSED;
      drive_on        <= 1'b0;
    end else if (advance) begin
      opening_pending <= opening_pending_next;
      phase           <= phase_next;
      elapsed_count   <= elapsed_count_next;
      attempt_count   <= attempt_count_next;
      sample_count    <= sample_count_next;
      debounce_level  <= debounce_level_next;
      door_state      <= door_state_next;
      drive_on        <= drive_on_next;
    end
  end

  // result of the beat being retired
  assign res_valid          = advance;
  assign res.latch_drive    = drive_on_next;
  assign res.door_status    = door_state_next;
  assign res.request_busy   = busy;
  assign res.opening_active = opening_pending_next;

endmodule

// ===== sv/dlprc_out.sv =====
// ----------------------------------------------------------------------------
// dlprc_out: two-entry output buffer
// Registers results and absorbs one beat of downstream stall.
// ----------------------------------------------------------------------------
module dlprc_out (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  res_valid,
  input  dlprc_pkg::result_t                    res,
  output logic                                  res_room,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [dlprc_pkg::OUT_DATA_W-1:0]      m_tdata
);

  logic [1:0]         count;
  dlprc_pkg::result_t head;
  dlprc_pkg::result_t skid;
  logic               pop;

  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign res_room = (count != 2'd2) || m_tready;
  assign m_tdata  = dlprc_pkg::OUT_DATA_W'(head);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, res_valid} - {1'b0, pop};
    end
  end

  // data movement
  always_ff @(posedge clk) begin
    priority if (res_valid && pop) begin
      if (count == 2'd2) begin
        head <= skid;
        skid <= res;
      end else begin
        head <= res;
      end
    end else if (res_valid) begin
      if (count == 2'd0) begin
        head <= res;
      end else begin
        skid <= res;
      end
    end else if (pop) begin
      head <= skid;
    end else begin
      // nothing moves, both entries hold
      head <= head;
    end
  end

endmodule
